@@ hdl/scba_pkg.sv @@
// Shared types and constants of the size-class bitmap allocator.
package scba_pkg;
	localparam int NumPoolsDef = 4;
	localparam int MaxBlocksDef = 64;
	localparam int QueueDepthDef = 2;
	localparam int SizeW = 13;
	localparam int CountW = 7;
	localparam int ReqW = 16;
	localparam int OffW = 20;
	localparam int StatW = 3;
	localparam int PoolW = 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 13;

	localparam logic [StatW-1:0] ST_ALLOC    = 3'd0;
	localparam logic [StatW-1:0] ST_TOO_BIG  = 3'd1;
	localparam logic [StatW-1:0] ST_NO_MEM   = 3'd2;
	localparam logic [StatW-1:0] ST_FREED    = 3'd3;
	localparam logic [StatW-1:0] ST_NO_POOL  = 3'd4;
	localparam logic [StatW-1:0] ST_MISALIGN = 3'd5;

	// queued item after classification
	typedef struct packed {
		logic            kind;
		logic            too_big;
		logic [ReqW-1:0] req;
		logic [OffW-1:0] off;
	} cmd_t;
endpackage

@@ hdl/scba_front.sv @@
// Front end: take items, flag oversize requests, queue them for the back end.
module scba_front import scba_pkg::*; #(
	parameter int Depth = QueueDepthDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            kind,
	input  logic [ReqW-1:0] request_size,
	input  logic [OffW-1:0] release_offset,
	input  logic [SizeW-1:0] last_size,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output cmd_t            cmd
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	cmd_t            fifo_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	cmd_t            c;
	logic            push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(Depth));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		c.kind    = kind;
		c.req     = request_size;
		c.off     = release_offset;
		c.too_big = ({3'b0, last_size} < request_size);
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ hdl/scba_div.sv @@
// Restoring divider: quotient and remainder of a 20-bit value by a 13-bit size.
module scba_div import scba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [OffW-1:0]  dividend,
	input  logic [SizeW-1:0] divisor,
	output logic             done,
	output logic [OffW-1:0]  quot,
	output logic [SizeW-1:0] rem
);
	logic [OffW-1:0]  q_q;
	logic [SizeW:0]   r_q;
	logic [SizeW-1:0] d_q;
	logic [4:0]       n_q;
	logic             busy_q;
	logic [SizeW:0]   sh;
	logic [SizeW+1:0] diff;

	assign sh   = {r_q[SizeW-1:0], q_q[OffW-1]};
	assign diff = {1'b0, sh} - {2'b0, d_q};
	assign quot = q_q;
	assign rem  = r_q[SizeW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			n_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= 5'(OffW);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[SizeW+1]) begin
				r_q <= diff[SizeW:0];
				q_q <= {q_q[OffW-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[OffW-2:0], 1'b0};
			end
		end
	end
endmodule

@@ hdl/scba_back.sv @@
// Back end: pool bitmaps, pool walk, slot search and divider-based release.
module scba_back import scba_pkg::*; #(
	parameter int NumPools  = NumPoolsDef,
	parameter int MaxBlocks = MaxBlocksDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  cmd_t                      cmd,
	input  logic [NumPools-1:0][SizeW-1:0]  bsize,
	input  logic [NumPools-1:0][CountW-1:0] bcount,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [StatW-1:0]          status,
	output logic [OffW-1:0]           block_offset,
	output logic [PoolW-1:0]          pool_index
);
	localparam int PW = (NumPools > 1) ? $clog2(NumPools) : 1;
	localparam int SW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
	localparam int CW = $clog2(MaxBlocks + 1);
	localparam int BW = 32;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_POOL = 6'b000010, S_SCAN = 6'b000100,
		S_DIV  = 6'b001000, S_WAITD = 6'b010000, S_OUT = 6'b100000
	} state_t;

	state_t                 st_q;
	logic [MaxBlocks-1:0]   map_q [NumPools];
	cmd_t                   cmd_q;
	logic [PW-1:0]          p_q;
	logic [SW-1:0]          s_q;
	logic [BW-1:0]          base_q, span_q;
	logic [StatW-1:0]       stat_q;
	logic [OffW-1:0]        boff_q;
	logic [PoolW-1:0]       pidx_q;
	logic [CW-1:0]          slots;
	logic [BW-1:0]          span;
	logic                   last_p, last_s;
	logic                   dstart, ddone;
	logic [OffW-1:0]        dquot;
	logic [SizeW-1:0]       drem;
	logic [BW-1:0]          rel;

	always_comb begin
		slots = '0;
		if (bsize[p_q] != '0)
			slots = (BW'(bcount[p_q]) > BW'(MaxBlocks)) ? CW'(MaxBlocks)
				: CW'(bcount[p_q]);
		span   = BW'(bsize[p_q]) * BW'(slots);
		last_p = (p_q == PW'(NumPools-1));
		last_s = ({1'b0, s_q} + 1'b1 >= (SW+1)'(slots));
		rel    = BW'(cmd_q.off) - base_q;
	end

	assign cmd_ready    = (st_q == S_IDLE);
	assign out_valid    = (st_q == S_OUT);
	assign status       = stat_q;
	assign block_offset = boff_q;
	assign pool_index   = pidx_q;
	assign dstart       = (st_q == S_DIV);

	scba_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.dividend(rel[OffW-1:0]), .divisor(bsize[p_q]),
		.done(ddone), .quot(dquot), .rem(drem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			for (int i = 0; i < NumPools; i++) map_q[i] <= '1;
		end else begin
			unique case (st_q)
				S_IDLE: if (cmd_valid) begin
					if (!cmd.kind && cmd.too_big) st_q <= S_OUT;
					else st_q <= S_POOL;
				end
				S_POOL: begin
					if (!cmd_q.kind) begin
						if (bsize[p_q] >= cmd_q.req[SizeW-1:0] && cmd_q.req[15:13] == '0
							&& slots != '0)
							st_q <= S_SCAN;
						else if (last_p) st_q <= S_OUT;
					end else begin
						if (BW'(cmd_q.off) >= base_q && rel < span) st_q <= S_DIV;
						else if (last_p) st_q <= S_OUT;
					end
				end
				S_SCAN: begin
					if (map_q[p_q][s_q]) begin
						map_q[p_q][s_q] <= 1'b0;
						st_q <= S_OUT;
					end else if (last_s) begin
						st_q <= last_p ? S_OUT : S_POOL;
					end
				end
				S_DIV:   st_q <= S_WAITD;
				S_WAITD: if (ddone) begin
					if (drem == '0) map_q[p_q][dquot[SW-1:0]] <= 1'b1;
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				cmd_q  <= cmd;
				p_q    <= '0;
				s_q    <= '0;
				base_q <= '0;
				boff_q <= '0;
				pidx_q <= '0;
				stat_q <= cmd.kind ? ST_NO_POOL : (cmd.too_big ? ST_TOO_BIG : ST_NO_MEM);
			end
			S_POOL: begin
				span_q <= span;
				s_q    <= '0;
				if (!cmd_q.kind) begin
					if (!(bsize[p_q] >= cmd_q.req[SizeW-1:0] && cmd_q.req[15:13] == '0
						&& slots != '0) && !last_p) begin
						base_q <= base_q + span;
						p_q    <= p_q + 1'b1;
					end
				end else if (!(BW'(cmd_q.off) >= base_q && rel < span) && !last_p) begin
					base_q <= base_q + span;
					p_q    <= p_q + 1'b1;
				end
			end
			S_SCAN: begin
				if (map_q[p_q][s_q]) begin
					stat_q <= ST_ALLOC;
					pidx_q <= PoolW'(p_q);
					boff_q <= OffW'(base_q + BW'(s_q) * BW'(bsize[p_q]));
				end else if (last_s && !last_p) begin
					base_q <= base_q + span_q;
					p_q    <= p_q + 1'b1;
				end else begin
					s_q <= s_q + 1'b1;
				end
			end
			S_WAITD: if (ddone) begin
				pidx_q <= PoolW'(p_q);
				stat_q <= (drem == '0) ? ST_FREED : ST_MISALIGN;
			end
			default: ;
		endcase
	end
endmodule

@@ hdl/size_class_bitmap_allocator.sv @@
// Size-class bitmap allocator: config registers, front queue and back end.
// A too-big request goes straight to the result; an allocation walks the pools and
// scans their slots; a free walks the pools up to the holding pool and then runs
// the 20-step serial divider; a free that is in no pool walks every pool.
// One item in the back end at a time: the next is taken once the last result is accepted.
// Reset (arst_n, async): sizes 32/64/128/256, counts 64, every slot free.
module size_class_bitmap_allocator import scba_pkg::*; #(
	parameter int NumPools  = NumPoolsDef,
	parameter int MaxBlocks = MaxBlocksDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [ReqW-1:0]    request_size,
	input  logic [OffW-1:0]    release_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [StatW-1:0]   status,
	output logic [OffW-1:0]    block_offset,
	output logic [PoolW-1:0]   pool_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDatW-1:0] cfg_data
);
	logic [NumPools-1:0][SizeW-1:0]  size_q;
	logic [NumPools-1:0][CountW-1:0] count_q;
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumPools; i++) begin
				size_q[i]  <= (i < 8) ? SizeW'((32 << i) > 4096 ? 4096 : (32 << i))
					: SizeW'(4096);
				count_q[i] <= CountW'(64);
			end
		end else if (cfg_valid) begin
			for (int i = 0; i < NumPools; i++) begin
				if (i < 4 && cfg_index == CfgIdxW'(i)) size_q[i] <= cfg_data;
				if (i < 4 && cfg_index == CfgIdxW'(i + 4)) count_q[i] <= cfg_data[CountW-1:0];
			end
		end
	end

	scba_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .request_size(request_size), .release_offset(release_offset),
		.last_size(size_q[NumPools-1]), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .cmd(cmd)
	);

	scba_back #(.NumPools(NumPools), .MaxBlocks(MaxBlocks)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .bsize(size_q), .bcount(count_q), .out_valid(out_valid),
		.out_ready(out_ready), .status(status), .block_offset(block_offset),
		.pool_index(pool_index)
	);
endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the size-class bitmap allocator.
module tb_top;
	import scba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;
	localparam logic [CfgIdxW-1:0] REG_SIZE0  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_COUNT0 = 3'd4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 130;

	typedef struct packed {
		logic [StatW-1:0] st;
		logic [OffW-1:0]  off;
		logic [PoolW-1:0] pool;
	} alloc_result_t;

	typedef struct {
		logic          kind;
		int unsigned   req;
		int unsigned   off;
		bit            typed;
		alloc_result_t res;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic in_kind = 1'b0;
	logic [ReqW-1:0] in_req = '0;
	logic [OffW-1:0] in_off = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [StatW-1:0] status;
	logic [OffW-1:0] block_offset;
	logic [PoolW-1:0] pool_index;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDatW-1:0] cfg_data = '0;

	// predictor state
	int unsigned pool_size [NumPoolsDef];
	int unsigned pool_count [NumPoolsDef];
	logic [MaxBlocksDef-1:0] free_bits [NumPoolsDef];

	alloc_result_t pending[$];
	int unsigned live_blocks[$];
	int errors = 0;
	bit no_idle = 1'b0;

	size_class_bitmap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(in_kind), .request_size(in_req), .release_offset(in_off),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .block_offset(block_offset), .pool_index(pool_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#20ms;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic int unsigned slots(int p);
		if (pool_size[p] == 0) return 0;
		return (pool_count[p] > MaxBlocksDef) ? MaxBlocksDef : pool_count[p];
	endfunction

	function automatic int unsigned pool_base(int p);
		int unsigned b;
		b = 0;
		for (int q = 0; q < p; q++) b += pool_size[q] * slots(q);
		return b;
	endfunction

	function automatic alloc_result_t serve(logic k, int unsigned req, int unsigned off);
		alloc_result_t r;
		int unsigned rel;
		r = '{st: ST_NO_MEM, off: '0, pool: '0};
		if (k == KIND_ALLOC) begin
			if (req > pool_size[NumPoolsDef-1]) begin
				r.st = ST_TOO_BIG;
				return r;
			end
			for (int p = 0; p < NumPoolsDef; p++) begin
				if (pool_size[p] < req) continue;
				for (int s = 0; s < slots(p); s++) begin
					if (free_bits[p][s]) begin
						free_bits[p][s] = 1'b0;
						r.st = ST_ALLOC;
						r.off = OffW'(pool_base(p) + s * pool_size[p]);
						r.pool = PoolW'(p);
						return r;
					end
				end
			end
			return r;
		end
		r.st = ST_NO_POOL;
		for (int p = 0; p < NumPoolsDef; p++) begin
			if (off < pool_base(p) || off - pool_base(p) >= pool_size[p] * slots(p)) continue;
			rel = off - pool_base(p);
			r.pool = PoolW'(p);
			if (rel % pool_size[p] != 0) begin
				r.st = ST_MISALIGN;
			end else begin
				free_bits[p][rel / pool_size[p]] = 1'b1;
				r.st = ST_FREED;
			end
			return r;
		end
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stall pattern
	initial begin
		int n;
		forever begin
			@(negedge clk);
			n = gap_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t e;
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("unexpected item: status %0d offset %0d pool %0d",
					status, block_offset, pool_index);
				errors++;
			end else begin
				e = pending.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d got %0d", e.st, status);
					errors++;
				end
				if (block_offset !== e.off) begin
					$error("block_offset expected %0d got %0d", e.off, block_offset);
					errors++;
				end
				if (pool_index !== e.pool) begin
					$error("pool_index expected %0d got %0d", e.pool, pool_index);
					errors++;
				end
			end
		end
	end

	task automatic send_item(logic k, int unsigned req, int unsigned off,
			bit typed = 1'b0, alloc_result_t want = '0);
		alloc_result_t r;
		int n;
		n = gap_len();
		@(negedge clk);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_kind <= k;
		in_req <= ReqW'(req);
		in_off <= OffW'(off);
		do @(posedge clk); while (!in_ready);
		r = serve(k, ReqW'(req), OffW'(off));
		if (r.st == ST_ALLOC) live_blocks.push_back(r.off);
		pending.push_back(typed ? want : r);
	endtask

	// hold off until every result is in and the block has settled
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDatW'(val);
		do @(posedge clk); while (!cfg_ready);
		if (idx < REG_COUNT0) pool_size[idx] = val & 13'h1FFF;
		else pool_count[idx - REG_COUNT0] = val & 7'h7F;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 4096;
			3: return 8191;
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	task automatic configure(int ph);
		int unsigned sz [NumPoolsDef];
		int unsigned cnt [NumPoolsDef];
		for (int p = 0; p < NumPoolsDef; p++) begin
			case (ph % 5)
				0: begin
					sz[p] = (p + 1) * $urandom_range(1, 16);
					cnt[p] = $urandom_range(0, 6);
				end
				1: begin
					sz[p] = (p == NumPoolsDef - 1) ? 4096 : p + 1;
					cnt[p] = (p % 2) ? 0 : 64;
				end
				2: begin
					sz[p] = 8191;
					cnt[p] = 127;
				end
				3: begin
					sz[p] = pick_size();
					cnt[p] = $urandom_range(0, 127);
				end
				default: begin
					sz[p] = $urandom_range(1, 4096);
					cnt[p] = $urandom_range(1, 10);
				end
			endcase
		end
		for (int p = 0; p < NumPoolsDef; p++) begin
			write_reg(CfgIdxW'(int'(REG_SIZE0) + p), sz[p]);
			write_reg(CfgIdxW'(int'(REG_COUNT0) + p), cnt[p]);
		end
		live_blocks.delete();
	endtask

	task automatic random_item();
		int r;
		int unsigned top;
		int idx;
		top = (pool_size[NumPoolsDef-1] == 0) ? 1 : pool_size[NumPoolsDef-1];
		r = $urandom_range(0, 99);
		if (r < 50) begin
			r = $urandom_range(0, 99);
			if (r < 8) send_item(KIND_ALLOC, $urandom_range(0, 1), 0);
			else if (r < 20) send_item(KIND_ALLOC, $urandom_range(0, 65535), 0);
			else if (r < 40) send_item(KIND_ALLOC, pool_size[$urandom_range(0, 3)], 0);
			else send_item(KIND_ALLOC, $urandom_range(1, top), 0);
		end else if (r < 88 && live_blocks.size() != 0) begin
			idx = $urandom_range(0, live_blocks.size() - 1);
			if ($urandom_range(0, 9) == 0) begin
				send_item(KIND_FREE, 0, live_blocks[idx] + 1);
			end else begin
				send_item(KIND_FREE, 0, live_blocks[idx]);
				live_blocks.delete(idx);
			end
		end else if (r < 94) begin
			send_item(KIND_FREE, 0, $urandom_range(0, 20'hFFFFF));
		end else begin
			send_item(KIND_FREE, 0, $urandom_range(0, pool_base(NumPoolsDef - 1) + 4 * top));
		end
	endtask

	initial begin
		table_row_t plan [14];
		plan = '{
			'{KIND_ALLOC, 0,     0,       1, '{ST_ALLOC, 0, 0}},
			'{KIND_ALLOC, 32,    0,       1, '{ST_ALLOC, 32, 0}},
			'{KIND_ALLOC, 33,    0,       1, '{ST_ALLOC, 2048, 1}},
			'{KIND_ALLOC, 256,   0,       1, '{ST_ALLOC, 14336, 3}},
			'{KIND_ALLOC, 257,   0,       1, '{ST_TOO_BIG, 0, 0}},
			'{KIND_ALLOC, 65535, 0,       1, '{ST_TOO_BIG, 0, 0}},
			'{KIND_FREE,  0,     0,       1, '{ST_FREED, 0, 0}},
			'{KIND_FREE,  0,     0,       1, '{ST_FREED, 0, 0}},
			'{KIND_FREE,  0,     1,       1, '{ST_MISALIGN, 0, 0}},
			'{KIND_FREE,  0,     30720,   1, '{ST_NO_POOL, 0, 0}},
			'{KIND_FREE,  0,     1048575, 1, '{ST_NO_POOL, 0, 0}},
			'{KIND_FREE,  0,     2048,    1, '{ST_FREED, 0, 1}},
			'{KIND_FREE,  0,     14591,   1, '{ST_MISALIGN, 0, 3}},
			'{KIND_ALLOC, 1,     0,       0, '{ST_ALLOC, 0, 0}}
		};
		for (int p = 0; p < NumPoolsDef; p++) begin
			pool_size[p] = 32 << p;
			pool_count[p] = 64;
			free_bits[p] = '1;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_item(plan[i].kind, plan[i].req, plan[i].off, plan[i].typed, plan[i].res);
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			configure(ph);
			no_idle = (ph == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 3 && i == PHASE_ITEMS / 2) drain();
				random_item();
			end
		end
		no_idle = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
